FILE: rtl/mbd_pkg.sv
// Shared types, constants and helpers for the mask bevel distance blend block.
// No dependencies; imported by mbd_blend and the top-level core.
package mbd_pkg;

    localparam int NUM_PIX    = 65536;
    localparam int PIX_ADDR_W = $clog2(NUM_PIX);
    localparam int DIST_W     = 8;
    localparam int CNT_W      = PIX_ADDR_W + 1;
    localparam int SIZE_W     = 9;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'((1 << DIST_W) - 2);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(256);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_INNER  = 2'd2,
        CFG_OUTER  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] inner;
        logic [COLOR_W-1:0] outer;
        logic [DIST_W-1:0]  dval;
        logic [DIST_W-1:0]  step;
    } t_blend_req;

    // distance plus one, held at the saturation level
    function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        r = (v >= DIST_SAT) ? DIST_SAT : v + DIST_W'(1);
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/mbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/mbd_blend.sv
// Per-channel weighted blend (inner*d + outer*(s-d)) / s with a radix-2 divider.
// Depends on mbd_pkg. Steps in order: capture the request, multiply, then divide one quotient bit at a time.
module mbd_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  mbd_pkg::t_blend_req        i_req,
    output logic                       o_done,
    output logic [mbd_pkg::COLOR_W-1:0] o_color
);
    import mbd_pkg::*;

    localparam int NUM_W = CH_W + DIST_W;
    localparam int NCH   = COLOR_W / CH_W;
    localparam int ITW   = $clog2(DIST_W + 1);

    typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV} t_bstate;

    t_bstate            r_state;
    t_blend_req         r_req;
    logic [ITW-1:0]     r_iter;
    logic [DIST_W-1:0]  r_rem [NCH];
    logic [CH_W-1:0]    r_sh  [NCH];
    logic [NUM_W-1:0]   n_num [NCH];
    logic [DIST_W-1:0]  n_rem [NCH];
    logic [CH_W-1:0]    n_sh  [NCH];
    logic               r_done;

    always_comb begin
        logic [CH_W-1:0]   a, b;
        logic [DIST_W:0]   t;
        for (int c = 0; c < NCH; c++) begin
            a = r_req.inner[c*CH_W +: CH_W];
            b = r_req.outer[c*CH_W +: CH_W];
            n_num[c] = NUM_W'(a) * NUM_W'(r_req.dval)
                     + NUM_W'(b) * NUM_W'(r_req.step - r_req.dval);
            t = {r_rem[c], r_sh[c][CH_W-1]};
            if (t >= {1'b0, r_req.step}) begin
                n_rem[c] = DIST_W'(t - {1'b0, r_req.step});
                n_sh[c]  = {r_sh[c][CH_W-2:0], 1'b1};
            end else begin
                n_rem[c] = DIST_W'(t);
                n_sh[c]  = {r_sh[c][CH_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    // quotient fits one channel, so the high half is already below s
                    for (int c = 0; c < NCH; c++) begin
                        r_rem[c] <= n_num[c][NUM_W-1 -: DIST_W];
                        r_sh[c]  <= n_num[c][CH_W-1:0];
                    end
                    r_iter  <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    for (int c = 0; c < NCH; c++) begin
                        r_rem[c] <= n_rem[c];
                        r_sh[c]  <= n_sh[c];
                    end
                    r_iter <= r_iter + ITW'(1);
                    if (r_iter == ITW'(CH_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            o_color[c*CH_W +: CH_W] = r_sh[c];
        end
    end
    assign o_done = r_done;
endmodule

FILE: rtl/mask_bevel_distance_blend_core.sv
// Top level of the mask bevel distance blend block: command FSM, distance passes, output.
// Depends on mbd_pkg, mbd_ram and mbd_blend.
//
// Loads a selection mask one pixel per item, computes city-block distances from the
// selection edge, and per read returns a distance-weighted blend of two colors for a
// covered pixel, black for an uncovered one. A read runs S_RD, then S_BLEND only when
// covered (radix-2 divider, one quotient bit per cycle), then S_OUT. A compute runs a
// forward sweep over all 65536 distance entries, then a backward sweep over the image in
// use and S_FIN; as the distance memory has a single read port, each backward pixel reads
// its lower neighbor and itself in separate states. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module mask_bevel_distance_blend_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbd_pkg::COLOR_W-1:0]    i_cfg_data,
    // input items
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [23:0]                    i_s_tdata,  // [15:0] pixel_index, [16] mask_bit, rest 0
    input  logic [1:0]                     i_s_tuser,  // [1:0] opcode
    // result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,  // [23:0] color, [31:24] final_step
    output logic                           o_m_tuser   // [0] covered
);
    import mbd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_BLEND, S_F_RD, S_F_WR, S_B_RD1, S_B_RD2, S_B_WR, S_FIN, S_OUT
    } t_state;

    t_state                 r_state;
    logic [SIZE_W-1:0]      r_wu, r_hu;
    logic [COLOR_W-1:0]     r_inner, r_outer;
    logic [CNT_W-1:0]       r_n;
    logic [DIST_W-1:0]      r_step, r_maxd, r_left, r_right, r_down;
    logic [PIX_ADDR_W-1:0]  r_p, r_idx;
    logic [CH_W-1:0]        r_x;
    logic [COLOR_W-1:0]     r_res_color;
    logic                   r_res_cov;
    logic [DIST_W-1:0]      r_res_fs;
    logic                   r_out_valid;
    logic [COLOR_W-1:0]     r_out_color;
    logic                   r_out_cov;
    logic [DIST_W-1:0]      r_out_fs;

    t_opcode                in_op;
    logic [PIX_ADDR_W-1:0]  in_idx;
    logic                   in_acc;
    logic                   mask_we, mask_q, dist_we;
    logic [PIX_ADDR_W-1:0]  mask_raddr, dist_raddr;
    logic [DIST_W-1:0]      dist_q, dist_wdata;
    logic [CH_W-1:0]        x_last;
    logic                   slot_free;
    logic [DIST_W-1:0]      f_up, f_left, f_min, b_right, b_down, b_min;
    logic                   f_in, b_has_down, rd_cov;
    logic [DIST_W-1:0]      rd_dist;
    logic                   blend_start, blend_done;
    t_blend_req             blend_req;
    logic [COLOR_W-1:0]     blend_color;

    assign in_op     = t_opcode'(i_s_tuser);
    assign in_idx    = i_s_tdata[PIX_ADDR_W-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc    = i_s_tvalid && o_s_tready;
    assign x_last    = CH_W'(r_wu - SIZE_W'(1));
    assign slot_free = !r_out_valid || i_m_tready;

    // memory addressing
    always_comb begin
        mask_raddr = in_idx;
        dist_raddr = in_idx;
        unique case (r_state)
            S_F_RD:  begin
                mask_raddr = r_p;
                dist_raddr = r_p - PIX_ADDR_W'(r_wu);
            end
            S_B_RD1: dist_raddr = r_p + PIX_ADDR_W'(r_wu);
            S_B_RD2: dist_raddr = r_p;
            default: ;
        endcase
    end

    assign mask_we = in_acc && (in_op == OP_LOAD);

    // forward pass: distance from top and left
    always_comb begin
        f_in   = {1'b0, r_p} < r_n;
        f_up   = ({1'b0, r_p} >= CNT_W'(r_wu)) ? dist_q : '0;
        f_left = (r_x == '0) ? '0 : r_left;
        f_min  = (f_up < f_left) ? f_up : f_left;
    end

    // backward pass: refine with right and bottom neighbors
    always_comb begin
        b_has_down = (CNT_W'(r_p) + CNT_W'(r_wu)) < r_n;
        b_right    = (r_x == x_last) ? DIST_W'(1) : inc_sat(r_right);
        b_down     = b_has_down ? inc_sat(r_down) : DIST_W'(1);
        b_min      = (b_right < b_down) ? b_right : b_down;
        if (dist_q < b_min) begin
            b_min = dist_q;
        end
    end

    always_comb begin
        dist_we    = 1'b0;
        dist_wdata = '0;
        if (r_state == S_F_WR) begin
            dist_we    = 1'b1;
            dist_wdata = (f_in && mask_q) ? inc_sat(f_min) : '0;
        end else if (r_state == S_B_WR) begin
            dist_we    = 1'b1;
            dist_wdata = b_min;
        end
    end

    // read lookup
    always_comb begin
        rd_cov  = ({1'b0, r_idx} < r_n) && mask_q && (dist_q != '0) && (r_step != '0);
        rd_dist = (dist_q > r_step) ? r_step : dist_q;
    end

    assign blend_start = (r_state == S_RD) && rd_cov;
    assign blend_req   = '{inner: r_inner, outer: r_outer, dval: rd_dist, step: r_step};

    mbd_ram #(.WIDTH(1), .DEPTH(NUM_PIX)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (in_idx),
        .i_wdata (i_s_tdata[PIX_ADDR_W]),
        .i_raddr (mask_raddr),
        .o_rdata (mask_q)
    );

    mbd_ram #(.WIDTH(DIST_W), .DEPTH(NUM_PIX)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (r_p),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_q)
    );

    mbd_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_req   (blend_req),
        .o_done  (blend_done),
        .o_color (blend_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wu        <= SIZE_MAX;
            r_hu        <= SIZE_MAX;
            r_n         <= CNT_W'(NUM_PIX);
            r_inner     <= '0;
            r_outer     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // keep the clamped size and pixel count current with every size write
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH: begin
                        r_wu <= clamp_size(i_cfg_data[SIZE_W-1:0]);
                        r_n  <= CNT_W'(clamp_size(i_cfg_data[SIZE_W-1:0])) * CNT_W'(r_hu);
                    end
                    CFG_HEIGHT: begin
                        r_hu <= clamp_size(i_cfg_data[SIZE_W-1:0]);
                        r_n  <= CNT_W'(r_wu) * CNT_W'(clamp_size(i_cfg_data[SIZE_W-1:0]));
                    end
                    CFG_INNER:  r_inner <= i_cfg_data;
                    CFG_OUTER:  r_outer <= i_cfg_data;
                endcase
            end
            if (r_out_valid && i_m_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx <= in_idx;
                        unique case (in_op)
                            OP_COMPUTE: begin
                                r_p     <= '0;
                                r_x     <= '0;
                                r_maxd  <= '0;
                                r_state <= S_F_RD;
                            end
                            OP_READ:  r_state <= S_RD;
                            OP_LOAD, OP_NONE: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_res_color <= '0;
                    r_res_cov   <= 1'b0;
                    r_res_fs    <= r_step;
                    r_state     <= rd_cov ? S_BLEND : S_OUT;
                end
                S_BLEND: begin
                    if (blend_done) begin
                        r_res_color <= blend_color;
                        r_res_cov   <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_F_RD: r_state <= S_F_WR;
                S_F_WR: begin
                    r_left <= dist_wdata;
                    if (r_p == PIX_ADDR_W'(NUM_PIX - 1)) begin
                        // start backward sweep at the last pixel of the image
                        r_p     <= PIX_ADDR_W'(r_n - CNT_W'(1));
                        r_x     <= x_last;
                        r_state <= S_B_RD1;
                    end else begin
                        r_p     <= r_p + PIX_ADDR_W'(1);
                        r_x     <= (r_x == x_last) ? '0 : r_x + CH_W'(1);
                        r_state <= S_F_RD;
                    end
                end
                S_B_RD1: r_state <= S_B_RD2;
                S_B_RD2: begin
                    r_down  <= dist_q;
                    r_state <= S_B_WR;
                end
                S_B_WR: begin
                    r_right <= b_min;
                    if (b_min > r_maxd) begin
                        r_maxd <= b_min;
                    end
                    if (r_p == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_p     <= r_p - PIX_ADDR_W'(1);
                        r_x     <= (r_x == '0) ? x_last : r_x - CH_W'(1);
                        r_state <= S_B_RD1;
                    end
                end
                S_FIN: begin
                    r_step      <= ((r_maxd < DIST_W'(1)) ? DIST_W'(1) : r_maxd) + DIST_W'(1);
                    r_res_fs    <= ((r_maxd < DIST_W'(1)) ? DIST_W'(1) : r_maxd) + DIST_W'(1);
                    r_res_color <= '0;
                    r_res_cov   <= 1'b0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the output register frees up
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_color <= r_res_color;
                        r_out_cov   <= r_res_cov;
                        r_out_fs    <= r_res_fs;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_fs, r_out_color};
    assign o_m_tuser  = r_out_cov;

    a_uncovered_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[23:0] == '0))
        else $error("uncovered result carries a color");

    a_step_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_step >= DIST_W'(2)))
        else $error("step count below two after compute");

    a_back_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_WR) |-> (dist_wdata <= dist_q))
        else $error("backward pass raised a distance");
endmodule
